@@ rtl/core/lzw_compressor_variable_width_defines.svh @@
// ----------------------------------------------------------------------------
// LZW compressor assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LZW_COMPRESSOR_VARIABLE_WIDTH_DEFINES_SVH
`define LZW_COMPRESSOR_VARIABLE_WIDTH_DEFINES_SVH

// plain invariant, sampled on the rising clock edge
`define LZWCVW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lzw compressor assertion failed");

// same-cycle implication
`define LZWCVW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lzw compressor assertion failed");

// next-cycle implication
`define LZWCVW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lzw compressor assertion failed");

`endif

@@ rtl/core/lzwcvw_pkg.sv @@
// ----------------------------------------------------------------------------
// LZW compressor package
// Code constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzwcvw_pkg;

  localparam int unsigned DictEntriesDef = 4096;
  localparam int unsigned CodeW          = 12;
  localparam int unsigned WidthW         = 4;
  localparam int unsigned RootCodes      = 258;

  localparam logic [CodeW-1:0]  CodeClear = 12'd256;
  localparam logic [CodeW-1:0]  CodeFirst = 12'd258;
  localparam logic [CodeW-1:0]  CodeLimit = 12'd4095;
  localparam logic [CodeW-1:0]  Code512   = 12'd512;
  localparam logic [CodeW-1:0]  Code1024  = 12'd1024;
  localparam logic [CodeW-1:0]  Code2048  = 12'd2048;
  localparam logic [WidthW-1:0] WidthMin  = 4'd9;

  localparam logic OpData   = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef struct packed {
    logic capture;     // latch input item
    logic set_start;   // start CLEAR has gone out
    logic prefix_byte; // pending prefix = byte
    logic fc_read;     // read first_child[prefix]
    logic walk_init;   // cur = head, tail = none
    logic node_read;   // read byte/sibling at cur
    logic walk_hit;    // prefix = cur
    logic walk_next;   // tail = cur, cur = sibling
    logic link_write;  // hook new entry onto tail or parent
    logic entry_write; // write new entry, bump counters
    logic restart;     // empty dictionary
    logic emit;        // load output register
    logic emit_clear;  // 1: CLEAR, 0: pending prefix
    logic emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic op;
    logic prefix_none;
    logic start_sent;
    logic out_free;
    logic cur_none;
    logic byte_match;
    logic full_next;   // new entry makes the table full
  } ctrl_sts_t;

endpackage

@@ rtl/core/lzwcvw_if.sv @@
// ----------------------------------------------------------------------------
// LZW compressor channel interfaces
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lzwcvw_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] byte_value;

  modport source (output valid, output opcode, output byte_value, input ready);
  modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

interface lzwcvw_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] code;
  logic [3:0]  code_width;
  logic        last;

  modport source (output valid, output code, output code_width, output last, input ready);
  modport sink   (input valid, input code, input code_width, input last, output ready);
endinterface

@@ rtl/core/lzw_compressor_variable_width.sv @@
// ----------------------------------------------------------------------------
// LZW compressor, variable code width
// Byte-stream LZW encoder with 9..12 bit codes and a child/sibling dictionary.
// ----------------------------------------------------------------------------
//  channel | dir | payload                         | transfer when
//  in_i    | in  | opcode, byte_value              | valid & ready
//  out_o   | out | code, code_width, last          | valid & ready
//
//  Data byte with a pending prefix: capture, dispatch, first-child read and
//  walk setup, then a check and a node read per sibling visited (a hit ends
//  the walk), then emit, link and insert when no child matches. Each walk
//  step is one registered memory read. First stream byte: CLEAR, then prefix.
//  No clearing pass: root child heads (codes 0..257) carry valid bits that
//  reset and CLEAR drop at once; all other entries are written on creation.
//  A stalled result holds the controller; the next item is taken once the
//  last result of the current one sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzw_compressor_variable_width import lzwcvw_pkg::*; #(
  parameter int unsigned DICT_ENTRIES = DictEntriesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lzwcvw_in_if.sink    in_i,
  lzwcvw_out_if.source out_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  // sequencer: owns the item flow and all memory/emit timing
  lzwcvw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  assign in_i.ready = in_ready;

  // dictionary, counters and the result register
  lzwcvw_dp #(
    .DictEntries (DICT_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_byte_i   (in_i.byte_value),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_code_o  (out_o.code),
    .out_width_o (out_o.code_width),
    .out_last_o  (out_o.last)
  );

endmodule

@@ rtl/core/lzwcvw_ctrl.sv @@
// ----------------------------------------------------------------------------
// LZW compressor controller
// Sequences start CLEAR, dictionary walk, entry insert and flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzwcvw_ctrl import lzwcvw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o,
  output logic      in_ready_o
);

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StStart = 11'b00000000010,
    StDisp  = 11'b00000000100,
    StFc    = 11'b00000001000,
    StFcW   = 11'b00000010000,
    StChk   = 11'b00000100000,
    StNdW   = 11'b00001000000,
    StEmitP = 11'b00010000000,
    StLink  = 11'b00100000000,
    StEntry = 11'b01000000000,
    StClr   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;  // CLEAR from finish restarts with no prefix

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    fin_d   = fin_q;
    case (state_q)
      StIdle: begin
        if (sts_i.in_valid) begin
          cmd_o.capture = 1'b1;
          state_d       = StStart;
        end
      end
      StStart: begin
        if (sts_i.start_sent) begin
          state_d = StDisp;
        end else if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_clear = 1'b1;
          // a first data byte causes nothing else
          cmd_o.emit_last  = (sts_i.op == OpData);
          cmd_o.set_start  = 1'b1;
          state_d          = StDisp;
        end
      end
      StDisp: begin
        if (sts_i.op == OpFinish) begin
          fin_d   = 1'b1;
          state_d = StEmitP;
        end else if (sts_i.prefix_none) begin
          cmd_o.prefix_byte = 1'b1;
          state_d           = StIdle;
        end else begin
          fin_d   = 1'b0;
          state_d = StFc;
        end
      end
      StFc: begin
        cmd_o.fc_read = 1'b1;
        state_d       = StFcW;
      end
      StFcW: begin
        cmd_o.walk_init = 1'b1;
        state_d         = StChk;
      end
      StChk: begin
        if (sts_i.cur_none) begin
          state_d = StEmitP;
        end else begin
          cmd_o.node_read = 1'b1;
          state_d         = StNdW;
        end
      end
      StNdW: begin
        if (sts_i.byte_match) begin
          cmd_o.walk_hit = 1'b1;
          state_d        = StIdle;
        end else begin
          cmd_o.walk_next = 1'b1;
          state_d         = StChk;
        end
      end
      StEmitP: begin
        if (fin_q && sts_i.prefix_none) begin
          state_d = StClr;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = !fin_q && !sts_i.full_next;
          state_d         = fin_q ? StClr : StLink;
        end
      end
      StLink: begin
        cmd_o.link_write = 1'b1;
        state_d          = StEntry;
      end
      StEntry: begin
        cmd_o.entry_write = 1'b1;
        state_d           = sts_i.full_next ? StClr : StIdle;
      end
      StClr: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_clear = 1'b1;
          cmd_o.emit_last  = 1'b1;
          cmd_o.restart    = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

@@ rtl/core/lzwcvw_dp.sv @@
// ----------------------------------------------------------------------------
// LZW compressor datapath
// Dictionary memories, prefix/walk registers, counters and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzwcvw_dp import lzwcvw_pkg::*; #(
  parameter int unsigned DictEntries = DictEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_sts_t          sts_o,
  input  logic               in_valid_i,
  input  logic               in_opcode_i,
  input  logic [7:0]         in_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CodeW-1:0]   out_code_o,
  output logic [WidthW-1:0]  out_width_o,
  output logic               out_last_o
);

  localparam int unsigned AW = $clog2(DictEntries);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned RW = $clog2(RootCodes);
  localparam logic [LW-1:0] LinkNone = LW'(DictEntries);

  logic [7:0]    eb_mem [DictEntries];
  logic [LW-1:0] ns_mem [DictEntries];
  logic [LW-1:0] fc_mem [DictEntries];

  logic [7:0]    eb_rd_q;
  logic [LW-1:0] ns_rd_q, fc_rd_q;

  logic              op_q;
  logic [7:0]        byte_q;
  logic [LW-1:0]     prefix_q, cur_q, tail_q;
  logic [CodeW-1:0]  nfc_q, nfc_inc;
  logic [WidthW-1:0] width_q;
  logic              start_q;
  logic [RootCodes-1:0] root_vld_q;

  logic              out_vld_q, out_last_q;
  logic [CodeW-1:0]  out_code_q;
  logic [WidthW-1:0] out_w_q;

  logic          prefix_root, tail_none, out_free;
  logic [LW-1:0] head, nf_link;

  assign nfc_inc     = nfc_q + 12'd1;
  assign nf_link     = {1'b0, nfc_q[AW-1:0]};
  assign prefix_root = (prefix_q < LW'(RootCodes));
  assign tail_none   = tail_q[AW];
  assign head        = (prefix_root && !root_vld_q[prefix_q[RW-1:0]]) ? LinkNone : fc_rd_q;
  assign out_free    = !out_vld_q || out_ready_i;

  // dictionary memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.entry_write) eb_mem[nfc_q[AW-1:0]] <= byte_q;
    if (cmd_i.node_read)   eb_rd_q <= eb_mem[cur_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_write && !tail_none) begin
      ns_mem[tail_q[AW-1:0]] <= nf_link;
    end else if (cmd_i.entry_write) begin
      ns_mem[nfc_q[AW-1:0]] <= LinkNone;
    end
    if (cmd_i.node_read) ns_rd_q <= ns_mem[cur_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_write && tail_none) begin
      fc_mem[prefix_q[AW-1:0]] <= nf_link;
    end else if (cmd_i.entry_write) begin
      fc_mem[nfc_q[AW-1:0]] <= LinkNone;
    end
    if (cmd_i.fc_read) fc_rd_q <= fc_mem[prefix_q[AW-1:0]];
  end

  // payload of the current item and walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_opcode_i;
      byte_q <= in_byte_i;
    end
    if (cmd_i.walk_init) begin
      cur_q  <= head;
      tail_q <= LinkNone;
    end else if (cmd_i.walk_next) begin
      cur_q  <= ns_rd_q;
      tail_q <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q   <= LinkNone;
      nfc_q      <= CodeFirst;
      width_q    <= WidthMin;
      start_q    <= 1'b0;
      root_vld_q <= '0;
    end else begin
      if (cmd_i.set_start) start_q <= 1'b1;
      if (cmd_i.prefix_byte) prefix_q <= {{(LW-8){1'b0}}, byte_q};
      if (cmd_i.walk_hit)    prefix_q <= cur_q;
      if (cmd_i.link_write && tail_none && prefix_root) begin
        root_vld_q[prefix_q[RW-1:0]] <= 1'b1;
      end
      if (cmd_i.entry_write) begin
        nfc_q    <= nfc_inc;
        prefix_q <= {{(LW-8){1'b0}}, byte_q};
        if (nfc_inc == Code512 || nfc_inc == Code1024 || nfc_inc == Code2048) begin
          width_q <= width_q + 4'd1;
        end
      end
      if (cmd_i.restart) begin
        root_vld_q <= '0;
        nfc_q      <= CodeFirst;
        width_q    <= WidthMin;
        prefix_q   <= (op_q == OpFinish) ? LinkNone : {{(LW-8){1'b0}}, byte_q};
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_code_q <= cmd_i.emit_clear ? CodeClear : prefix_q[CodeW-1:0];
      out_w_q    <= width_q;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_code_o  = out_code_q;
  assign out_width_o = out_w_q;
  assign out_last_o  = out_last_q;

  assign sts_o.in_valid    = in_valid_i;
  assign sts_o.op          = op_q;
  assign sts_o.prefix_none = prefix_q[AW];
  assign sts_o.start_sent  = start_q;
  assign sts_o.out_free    = out_free;
  assign sts_o.cur_none    = cur_q[AW];
  assign sts_o.byte_match  = (eb_rd_q == byte_q);
  assign sts_o.full_next   = (nfc_inc == CodeLimit);

endmodule

@@ rtl/core/lzwcvw_checker.sv @@
// ----------------------------------------------------------------------------
// LZW compressor port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lzw_compressor_variable_width_defines.svh"

module lzwcvw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [11:0] out_code_i,
  input logic [3:0]  out_width_i,
  input logic        out_last_i
);

  // stalled result holds
  `LZWCVW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_code_i) && $stable(out_last_i))
  // width stays in range
  `LZWCVW_ASSERT_IMP(a_width_rng, clk_i, rst_ni, out_valid_i, out_width_i >= 4'd9 && out_width_i <= 4'd12)
  // a code fits in its width
  `LZWCVW_ASSERT_IMP(a_code_fits, clk_i, rst_ni, out_valid_i, out_width_i == 4'd12 || (out_code_i >> out_width_i) == 12'd0)
  // no new item while more results of the current one are due
  `LZWCVW_ASSERT_IMP(a_busy, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i)

endmodule

bind lzw_compressor_variable_width lzwcvw_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_code_i  (out_o.code),
  .out_width_i (out_o.code_width),
  .out_last_i  (out_o.last)
);
